// ----- rtl/core/mvp_pkg.sv -----
// Shared types and codes for the mapped view pool.
// No dependencies.
`timescale 1ns / 1ps
package mvp_pkg;

  localparam int StartW = 48;
  localparam int LenW   = 32;
  localparam int FileW  = 16;
  localparam int RefsW  = 16;
  localparam int BytesW = 40;

  // request kinds
  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_SETREF = 2'd2;

  // result status codes
  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_MISS     = 3'd1;
  localparam logic [2:0] ST_EVICTED  = 3'd2;
  localparam logic [2:0] ST_INSERTED = 3'd3;
  localparam logic [2:0] ST_REJECTED = 3'd4;
  localparam logic [2:0] ST_UPDATED  = 3'd5;

  typedef struct packed {
    logic [StartW-1:0] start;
    logic [LenW-1:0]   length;
    logic [FileW-1:0]  file;
    logic [RefsW-1:0]  refs;
  } entry_t;

endpackage

// ----- rtl/core/mvp_table.sv -----
// View table storage: one write port, one registered read port.
// Depends on mvp_pkg.
`timescale 1ns / 1ps
module mvp_table #(
  parameter int Depth = 16,
  parameter int AddrW = 4
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AddrW-1:0]      waddr_i,
  input  mvp_pkg::entry_t       wdata_i,
  input  logic [AddrW-1:0]      raddr_i,
  output mvp_pkg::entry_t       rdata_o
);
  import mvp_pkg::*;

  entry_t mem [Depth];
  entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/mapped_view_pool_replacement.sv -----
// Mapped view pool with LRU order and refcount-based eviction: sequencer top level.
// Depends on mvp_pkg and mvp_table.
//
//  channel   | signals                                        | flow
//  ----------+------------------------------------------------+---------------------------
//  request   | start, busy, kind_i .. ref_value_i             | word taken on start & !busy
//  result    | result_valid_o, status_o .. last_o             | one-cycle strobe per word, no stall
//  config    | max_pool_bytes_we_i, max_pool_bytes_i          | written on enable, no wait
//
// One shared compare unit walks the table through a single registered read port, reading
// each entry in one state and comparing it in another. A lookup or set-count searches newest
// first, and a lookup hit then moves the view to the newest slot; each eviction is a check,
// a victim scan (it stops at the first view with a count of one), then the shift.
// Reset empties the pool at once; the table itself is never cleared.
// Results come out as single-cycle strobes; the receiver cannot stall them.
`timescale 1ns / 1ps
module mapped_view_pool_replacement #(
  parameter int POOL_ENTRIES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  kind_i,
  input  logic [mvp_pkg::StartW-1:0]  file_offset_i,
  input  logic [mvp_pkg::FileW-1:0]   file_id_i,
  input  logic [mvp_pkg::LenW-1:0]    view_bytes_i,
  input  logic [mvp_pkg::RefsW-1:0]   ref_value_i,
  input  logic                        max_pool_bytes_we_i,
  input  logic [mvp_pkg::BytesW-1:0]  max_pool_bytes_i,
  output logic                        result_valid_o,
  output logic [2:0]                  status_o,
  output logic [mvp_pkg::StartW-1:0]  view_start_o,
  output logic [mvp_pkg::LenW-1:0]    view_length_o,
  output logic [mvp_pkg::FileW-1:0]   view_file_o,
  output logic [mvp_pkg::RefsW-1:0]   view_refs_o,
  output logic                        last_o
);
  import mvp_pkg::*;

  localparam int IW = $clog2(POOL_ENTRIES);
  localparam int CW = $clog2(POOL_ENTRIES + 1);
  localparam logic [CW-1:0] Full = CW'(POOL_ENTRIES);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SRD   = 8'b0000_0010,
    S_SCMP  = 8'b0000_0100,
    S_VRD   = 8'b0000_1000,
    S_VCMP  = 8'b0001_0000,
    S_SHRD  = 8'b0010_0000,
    S_SHWR  = 8'b0100_0000,
    S_CHK   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d, ptr_q, ptr_d, sh_q, sh_d;
  logic [BytesW-1:0] used_q, used_d, max_q;
  logic [1:0] kind_q, kind_d;
  entry_t req_q, req_d, hold_q, hold_d;
  logic [RefsW-1:0] least_q, least_d;
  logic [IW-1:0] best_q, best_d;
  logic evict_mode_q, evict_mode_d;

  logic res_v_d, last_d;
  logic [2:0] stat_d;
  entry_t res_d, res_q;
  logic [2:0] stat_q;
  logic res_v_q, last_q;

  // table port signals
  logic we;
  logic [IW-1:0] waddr, raddr;
  entry_t wdata, rdata;

  mvp_table #(.Depth(POOL_ENTRIES), .AddrW(IW)) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // shared compare unit: containment and pool-limit checks
  logic [StartW:0] view_end;
  logic            hit, over;
  assign view_end = {1'b0, rdata.start} + {{(StartW-LenW+1){1'b0}}, rdata.length};
  assign hit = ({1'b0, req_q.start} >= {1'b0, rdata.start}) &&
               ({1'b0, req_q.start} < view_end) && (rdata.file == req_q.file);
  assign over = ({1'b0, used_q} + {{(BytesW-LenW+1){1'b0}}, req_q.length}) >
                {1'b0, max_q};

  assign busy = (state_q != S_IDLE);

  // sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    sh_d         = sh_q;
    used_d       = used_q;
    kind_d       = kind_q;
    req_d        = req_q;
    hold_d       = hold_q;
    least_d      = least_q;
    best_d       = best_q;
    evict_mode_d = evict_mode_q;
    we           = 1'b0;
    waddr        = sh_q[IW-1:0];
    wdata        = hold_q;
    raddr        = ptr_q[IW-1:0];
    res_v_d      = 1'b0;
    last_d       = 1'b0;
    stat_d       = ST_MISS;
    res_d        = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          kind_d       = kind_i;
          req_d.start  = file_offset_i;
          req_d.length = view_bytes_i;
          req_d.file   = file_id_i;
          req_d.refs   = ref_value_i;
          ptr_d        = count_q;
          case (kind_i)
            KIND_LOOKUP, KIND_SETREF: state_d = S_SRD;
            KIND_INSERT:              state_d = S_CHK;
            default: begin
              res_v_d = 1'b1;
              last_d  = 1'b1;
            end
          endcase
        end
      end

      // newest-first search
      S_SRD: begin
        if (ptr_q == '0) begin
          res_v_d = 1'b1;
          last_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          raddr   = IW'(ptr_q - 1'b1);
          state_d = S_SCMP;
        end
      end

      S_SCMP: begin
        if (hit) begin
          if (kind_q == KIND_SETREF) begin
            we           = 1'b1;
            waddr        = IW'(ptr_q - 1'b1);
            wdata        = rdata;
            wdata.refs   = req_q.refs;
            res_v_d      = 1'b1;
            last_d       = 1'b1;
            stat_d       = ST_UPDATED;
            res_d        = wdata;
            state_d      = S_IDLE;
          end else begin
            hold_d       = rdata;
            sh_d         = ptr_q - 1'b1;
            evict_mode_d = 1'b0;
            state_d      = S_SHRD;
          end
        end else begin
          ptr_d   = ptr_q - 1'b1;
          state_d = S_SRD;
        end
      end

      // insert: decide evict, reject or append
      S_CHK: begin
        if (over || count_q == Full) begin
          if (count_q == '0) begin
            res_v_d = 1'b1;
            last_d  = 1'b1;
            stat_d  = ST_REJECTED;
            res_d   = req_q;
            state_d = S_IDLE;
          end else begin
            ptr_d   = '0;
            state_d = S_VRD;
          end
        end else begin
          we      = 1'b1;
          waddr   = count_q[IW-1:0];
          wdata   = req_q;
          count_d = count_q + 1'b1;
          used_d  = used_q + {{(BytesW-LenW){1'b0}}, req_q.length};
          res_v_d = 1'b1;
          last_d  = 1'b1;
          stat_d  = ST_INSERTED;
          res_d   = req_q;
          state_d = S_IDLE;
        end
      end

      // victim scan, oldest first
      S_VRD: begin
        state_d = S_VCMP;
      end

      S_VCMP: begin
        if (rdata.refs == RefsW'(1) || ptr_q + 1'b1 == count_q) begin
          if (rdata.refs == RefsW'(1) || ptr_q == '0 || rdata.refs < least_q) begin
            res_d = rdata;
            sh_d  = ptr_q;
          end else begin
            res_d = hold_q;
            sh_d  = CW'(best_q);
          end
          res_v_d      = 1'b1;
          stat_d       = ST_EVICTED;
          used_d       = used_q - {{(BytesW-LenW){1'b0}}, res_d.length};
          evict_mode_d = 1'b1;
          state_d      = S_SHRD;
        end else begin
          if (ptr_q == '0 || rdata.refs < least_q) begin
            least_d = rdata.refs;
            best_d  = ptr_q[IW-1:0];
            hold_d  = rdata;
          end
          ptr_d   = ptr_q + 1'b1;
          state_d = S_VRD;
        end
      end

      // close the gap at sh_q, reading each entry in S_SHRD and writing it in S_SHWR
      S_SHRD: begin
        if (sh_q + 1'b1 < count_q) begin
          raddr   = IW'(sh_q + 1'b1);
          state_d = S_SHWR;
        end else if (evict_mode_q) begin
          count_d = count_q - 1'b1;
          state_d = S_CHK;
        end else begin
          we      = 1'b1;
          waddr   = IW'(count_q - 1'b1);
          wdata   = hold_q;
          res_v_d = 1'b1;
          last_d  = 1'b1;
          stat_d  = ST_HIT;
          res_d   = hold_q;
          state_d = S_IDLE;
        end
      end

      S_SHWR: begin
        we      = 1'b1;
        waddr   = sh_q[IW-1:0];
        wdata   = rdata;
        sh_d    = sh_q + 1'b1;
        state_d = S_SHRD;
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      used_q  <= '0;
      max_q   <= BytesW'(268435456);
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      used_q  <= used_d;
      res_v_q <= res_v_d;
      if (max_pool_bytes_we_i) begin
        max_q <= max_pool_bytes_i;
      end
    end
  end

  // working and result words
  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    sh_q         <= sh_d;
    kind_q       <= kind_d;
    req_q        <= req_d;
    hold_q       <= hold_d;
    least_q      <= least_d;
    best_q       <= best_d;
    evict_mode_q <= evict_mode_d;
    res_q        <= res_d;
    stat_q       <= stat_d;
    last_q       <= last_d;
  end

  assign result_valid_o = res_v_q;
  assign status_o       = stat_q;
  assign view_start_o   = res_q.start;
  assign view_length_o  = res_q.length;
  assign view_file_o    = res_q.file;
  assign view_refs_o    = res_q.refs;
  assign last_o         = last_q;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for mapped_view_pool_replacement: directed table, then random traffic.
// Depends on mvp_pkg and the pool RTL; results are checked against an in-bench pool model.
`timescale 1ns / 1ps
module testbench;
  import mvp_pkg::*;

  localparam int Depth = 16;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [2:0] NoTyped = 3'd7;
  localparam logic [BytesW-1:0] ResetLimit = 40'd268435456;

  typedef struct packed {
    logic [2:0]        status;
    logic [StartW-1:0] start;
    logic [LenW-1:0]   length;
    logic [FileW-1:0]  file;
    logic [RefsW-1:0]  refs;
    logic              last;
  } word_t;

  typedef struct {
    logic [1:0]        kind;
    logic [StartW-1:0] offset;
    logic [FileW-1:0]  file;
    logic [LenW-1:0]   bytes;
    logic [RefsW-1:0]  refs;
    bit                typed;
    logic [2:0]        want_status;
  } req_t;

  logic clk_i = 1'b0, rst_ni = 1'b0, start = 1'b0, busy;
  logic [1:0] kind_i = '0;
  logic [StartW-1:0] file_offset_i = '0;
  logic [FileW-1:0] file_id_i = '0;
  logic [LenW-1:0] view_bytes_i = '0;
  logic [RefsW-1:0] ref_value_i = '0;
  logic max_pool_bytes_we_i = 1'b0;
  logic [BytesW-1:0] max_pool_bytes_i = '0;
  logic result_valid_o, last_o;
  logic [2:0] status_o;
  logic [StartW-1:0] view_start_o;
  logic [LenW-1:0] view_length_o;
  logic [FileW-1:0] view_file_o;
  logic [RefsW-1:0] view_refs_o;

  mapped_view_pool_replacement dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // pool shadow: slot 0 oldest
  entry_t      pool_q[$];
  logic [BytesW-1:0] used_bytes, limit_bytes;
  word_t       expected_words[$];
  logic [2:0]  typed_status[$];
  int          errors = 0;

  task automatic report(input string what);
    errors++;
    $display("ERROR %0t: %s", $realtime, what);
  endtask

  function automatic void queue_word(word_t w);
    expected_words.insert(expected_words.size(), w);
  endfunction

  function automatic void append_view(entry_t e);
    pool_q.insert(pool_q.size(), e);
  endfunction

  function automatic int find_view(logic [StartW-1:0] off, logic [FileW-1:0] fid);
    for (int i = pool_q.size() - 1; i >= 0; i--)
      if ({1'b0, off} >= {1'b0, pool_q[i].start} &&
          {1'b0, off} < {1'b0, pool_q[i].start} + pool_q[i].length &&
          pool_q[i].file == fid) return i;
    return -1;
  endfunction

  function automatic word_t mk(logic [2:0] st, entry_t e);
    word_t w;
    w = '{st, e.start, e.length, e.file, e.refs, 1'b0};
    return w;
  endfunction

  function automatic void evict_victim();
    int v;
    v = 0;
    for (int i = 0; i < pool_q.size(); i++) begin
      if (pool_q[i].refs == 1) begin
        v = i;
        break;
      end
      if (pool_q[i].refs < pool_q[v].refs) v = i;
    end
    queue_word(mk(ST_EVICTED, pool_q[v]));
    used_bytes = used_bytes - pool_q[v].length;
    pool_q.delete(v);
  endfunction

  // computes the words one request causes and updates the shadow pool
  function automatic void predict_pool(req_t r);
    int h;
    entry_t e;
    e = '{r.offset, r.bytes, r.file, r.refs};
    case (r.kind)
      KIND_LOOKUP: begin
        h = find_view(r.offset, r.file);
        if (h < 0) queue_word(mk(ST_MISS, '0));
        else begin
          e = pool_q[h];
          pool_q.delete(h);
          append_view(e);
          queue_word(mk(ST_HIT, e));
        end
      end
      KIND_INSERT: begin
        while (pool_q.size() > 0 && {1'b0, used_bytes} + r.bytes > {1'b0, limit_bytes})
          evict_victim();
        if ({1'b0, used_bytes} + r.bytes > {1'b0, limit_bytes})
          queue_word(mk(ST_REJECTED, e));
        else begin
          if (pool_q.size() >= Depth) evict_victim();
          append_view(e);
          used_bytes = used_bytes + r.bytes;
          queue_word(mk(ST_INSERTED, e));
        end
      end
      KIND_SETREF: begin
        h = find_view(r.offset, r.file);
        if (h < 0) queue_word(mk(ST_MISS, '0));
        else begin
          pool_q[h].refs = r.refs;
          queue_word(mk(ST_UPDATED, pool_q[h]));
        end
      end
      default: queue_word(mk(ST_MISS, '0));
    endcase
    expected_words[expected_words.size() - 1].last = 1'b1;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      word_t got, want;
      got = '{status_o, view_start_o, view_length_o, view_file_o, view_refs_o, last_o};
      if (expected_words.size() == 0) report("result word with nothing expected");
      else begin
        want = expected_words.pop_front();
        if (want.last && typed_status.size() > 0) begin
          if (typed_status[0] != NoTyped && got.status != typed_status[0])
            report($sformatf("typed status %0d got %0d", typed_status[0], got.status));
          void'(typed_status.pop_front());
        end
        if (got.status != want.status)
          report($sformatf("status exp %0d got %0d", want.status, got.status));
        if (got.start != want.start)
          report($sformatf("start exp %h got %h", want.start, got.start));
        if (got.length != want.length)
          report($sformatf("length exp %h got %h", want.length, got.length));
        if (got.file != want.file)
          report($sformatf("file exp %h got %h", want.file, got.file));
        if (got.refs != want.refs)
          report($sformatf("refs exp %h got %h", want.refs, got.refs));
        if (got.last != want.last)
          report($sformatf("last exp %0d got %0d", want.last, got.last));
      end
    end
  end

  // waits for an idle block, then raises start for exactly one accepting edge
  task automatic send(req_t r);
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    kind_i = r.kind; file_offset_i = r.offset; file_id_i = r.file;
    view_bytes_i = r.bytes; ref_value_i = r.refs; start = 1'b1;
    predict_pool(r);
    typed_status = {typed_status, (r.typed ? r.want_status : NoTyped)};
    @(negedge clk_i);
    start = 1'b0;
  endtask

  task automatic drain();
    while (expected_words.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_limit(logic [BytesW-1:0] v);
    drain();
    @(negedge clk_i);
    max_pool_bytes_i = v; max_pool_bytes_we_i = 1'b1;
    @(negedge clk_i);
    max_pool_bytes_we_i = 1'b0;
    limit_bytes = v;
  endtask

  function automatic req_t row(logic [1:0] k, logic [StartW-1:0] o, logic [FileW-1:0] f,
                               logic [LenW-1:0] b, logic [RefsW-1:0] rv,
                               bit t = 1'b0, logic [2:0] s = '0);
    req_t r;
    r = '{k, o, f, b, rv, t, s};
    return r;
  endfunction

  // random request, biased toward views already held
  function automatic req_t random_req(int span);
    req_t r;
    int p;
    r = row(2'($urandom_range(0, 2)), 48'($urandom_range(0, span)), 16'($urandom_range(0, 3)),
            32'($urandom_range(1, 64)), 16'($urandom_range(0, 3)));
    if ($urandom_range(0, 19) == 0) r.kind = KIND_UNUSED;
    if ($urandom_range(0, 9) == 0) begin
      r.offset = 48'({$urandom, $urandom});
      r.file = 16'($urandom);
      r.bytes = $urandom;
      r.refs = 16'($urandom);
    end
    if (r.kind != KIND_INSERT && pool_q.size() > 0 && $urandom_range(0, 3) != 0) begin
      p = $urandom_range(0, pool_q.size() - 1);
      r.file = pool_q[p].file;
      if (pool_q[p].length != 0)
        r.offset = pool_q[p].start + 48'($urandom_range(0, int'(pool_q[p].length) - 1) %
                   ((pool_q[p].length > 1000) ? 1000 : pool_q[p].length));
    end
    return r;
  endfunction

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    req_t dir_rows[$];
    int n;
    used_bytes = '0;
    limit_bytes = ResetLimit;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed rows
    dir_rows = '{
      row(KIND_LOOKUP, 48'd0, 16'd0, 32'd0, 16'd0, 1, ST_MISS),
      row(KIND_SETREF, 48'd5, 16'd0, 32'd0, 16'd3, 1, ST_MISS),
      row(KIND_UNUSED, 48'hFFFF_FFFF_FFFF, 16'hFFFF, '1, '1, 1, ST_MISS),
      row(KIND_INSERT, 48'd100, 16'd1, 32'd0, 16'd1, 1, ST_INSERTED),
      row(KIND_LOOKUP, 48'd100, 16'd1, 32'd0, 16'd0, 1, ST_MISS),
      row(KIND_INSERT, 48'hFFFF_FFFF_FFF0, 16'hFFFF, 32'd16, 16'hFFFF),
      row(KIND_LOOKUP, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 32'd0, 16'd0, 1, ST_HIT),
      row(KIND_INSERT, 48'd0, 16'd2, 32'd1000, 16'd0),
      row(KIND_LOOKUP, 48'd999, 16'd2, 32'd0, 16'd0, 1, ST_HIT),
      row(KIND_LOOKUP, 48'd1000, 16'd2, 32'd0, 16'd0, 1, ST_MISS),
      row(KIND_LOOKUP, 48'd10, 16'd3, 32'd0, 16'd0, 1, ST_MISS),
      row(KIND_SETREF, 48'd0, 16'd2, 32'd0, 16'd1, 1, ST_UPDATED),
      row(KIND_INSERT, 48'd7, 16'd4, 32'hFFFF_FFFF, 16'd9, 1, ST_REJECTED),
      row(KIND_INSERT, 48'd50, 16'd5, 32'h0FFF_FFFF, 16'd2)
    };
    foreach (dir_rows[i]) send(dir_rows[i]);

    // fill the table with small views; the last two inserts each force a victim
    for (int i = 0; i < 18; i++)
      send(row(KIND_INSERT, 48'(i * 10), 16'd7, 32'd10, 16'(2 + (i % 3))));
    set_limit(40'd0);
    send(row(KIND_INSERT, 48'd1, 16'd8, 32'd0, 16'd1));
    send(row(KIND_INSERT, 48'd1, 16'd8, 32'd1, 16'd1, 1, ST_REJECTED));
    set_limit('1);
    send(row(KIND_INSERT, 48'd3, 16'd9, '1, 16'd0, 1, ST_INSERTED));
    set_limit(40'd200);

    // random phases with bursts and gaps
    n = 0;
    for (int ph = 0; ph < 4; ph++) begin
      while (n < (ph + 1) * 100) begin
        int burst;
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst; b++) begin
          send(random_req(ph == 3 ? 2000 : 300));
          n++;
        end
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 30)) @(negedge clk_i);
        if (n % 50 == 0) while (expected_words.size() > 0) @(posedge clk_i);
      end
      case (ph)
        0: set_limit(40'd60);
        1: set_limit(40'd100000);
        2: set_limit(ResetLimit);
        default: ;
      endcase
    end

    drain();
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/core/mvp_pkg.sv
rtl/core/mvp_table.sv
rtl/core/mapped_view_pool_replacement.sv
tb/testbench.sv
